[design/stream_find_replace_top_assert.svh]
// Assertion macros for the stream find-and-replace block.
// Used by the port checker; depends on signals named clk and rst_n in scope.
`ifndef STREAM_FIND_REPLACE_TOP_ASSERT_SVH
`define STREAM_FIND_REPLACE_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define SFR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SFR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define SFR_ASSERT_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

[design/sfr_pkg.sv]
// Shared constants and types for the stream find-and-replace block.
// No dependencies; used by every module of the block but sfr_queue.
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 4;
  localparam int CFG_W  = 64;

  typedef enum logic [1:0] {
    CFG_NEEDLE_LEN   = 2'd0,
    CFG_NEEDLE_BYTES = 2'd1,
    CFG_REPL_LEN     = 2'd2,
    CFG_REPL_BYTES   = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

[design/stream_find_replace_top.sv]
// Top level of the stream find-and-replace block.
// Instantiates sfr_front, sfr_queue and sfr_back; depends on sfr_pkg.
//
// The block takes one text byte per cycle and replaces every leftmost,
// non-overlapping occurrence of the configured needle with the replacement.
// Each accepted byte that causes results becomes one job of one to eight
// result items (a bare end marker counts as one), and the back part plays
// a job out one item per cycle while the output is not stalled. A byte that
// causes k results becomes k output items, and a byte that only fills the
// pending window causes no job. A two-entry job queue lets input continue
// while a replacement or final flush expands, and the input stalls only when
// that queue is full.
// The configuration port is always ready and there is no clearing pass.
`default_nettype none

module stream_find_replace_top #(
  parameter int NEEDLE_MAX  = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  sfr_pkg::cfg_idx_t            cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sfr_pkg::BYTE_W-1:0]   in_text_byte,
  input  logic                         in_text_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sfr_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_byte_present,
  output logic                         out_end
);

  import sfr_pkg::*;

  localparam int JOB_MAX = (NEEDLE_MAX > REPLACE_MAX) ? NEEDLE_MAX : REPLACE_MAX;
  localparam int CW      = $clog2(JOB_MAX + 1);
  localparam int DATA_W  = JOB_MAX * BYTE_W + CW + 1;

  logic                      in_take, q_full, q_vld, q_pop;
  logic                      job_push, job_end, q_end;
  logic [JOB_MAX*BYTE_W-1:0] job_bytes, q_bytes;
  logic [CW-1:0]             job_cnt, q_cnt;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_take   = in_valid && !q_full;

  sfr_front #(
    .NEEDLE_MAX  (NEEDLE_MAX),
    .REPLACE_MAX (REPLACE_MAX),
    .JOB_MAX     (JOB_MAX)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_take      (in_take),
    .in_text_byte (in_text_byte),
    .in_text_end  (in_text_end),
    .job_push     (job_push),
    .job_bytes    (job_bytes),
    .job_cnt      (job_cnt),
    .job_end      (job_end)
  );

  sfr_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data ({job_end, job_cnt, job_bytes}),
    .pop       (q_pop),
    .pop_data  ({q_end, q_cnt, q_bytes}),
    .vld       (q_vld),
    .full      (q_full)
  );

  sfr_back #(
    .JOB_MAX (JOB_MAX)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_vld            (q_vld),
    .q_bytes          (q_bytes),
    .q_cnt            (q_cnt),
    .q_end            (q_end),
    .q_pop            (q_pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_end          (out_end)
  );

endmodule

`default_nettype wire

[design/sfr_queue.sv]
// Small register queue of jobs between the front and back parts.
// Depends on nothing but its parameters.
`default_nettype none

module sfr_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              vld,
  output logic              full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]   cnt_r;

  assign pop_data = mem_r[rd_ptr_r];
  assign vld      = (cnt_r != '0);
  assign full     = (cnt_r == CNTW'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/sfr_front.sv]
// Front part: configuration registers, pending window and needle compare.
// Turns each text byte into at most one job of output bytes. Depends on sfr_pkg.
`default_nettype none

module sfr_front #(
  parameter int NEEDLE_MAX  = 8,
  parameter int REPLACE_MAX = 8,
  parameter int JOB_MAX     = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  sfr_pkg::cfg_idx_t               cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_take,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_text_byte,
  input  logic                            in_text_end,
  output logic                            job_push,
  output logic [JOB_MAX*sfr_pkg::BYTE_W-1:0] job_bytes,
  output logic [$clog2(JOB_MAX+1)-1:0]    job_cnt,
  output logic                            job_end
);

  import sfr_pkg::*;

  localparam int NW = $clog2(NEEDLE_MAX + 1);
  localparam int CW = $clog2(JOB_MAX + 1);

  logic [LEN_W-1:0]               nlen_cfg_r, rlen_cfg_r;
  logic [NEEDLE_MAX*BYTE_W-1:0]   needle_r;
  logic [REPLACE_MAX*BYTE_W-1:0]  repl_r;
  logic [NEEDLE_MAX*BYTE_W-1:0]   win_r, win_nxt, win_new;
  logic [NW-1:0]                  cnt_r, cnt_nxt, nlen, pc, pc_new;
  logic [CW-1:0]                  rlen;
  logic                           full, match;

  always_comb begin
    nlen = (nlen_cfg_r > LEN_W'(NEEDLE_MAX)) ? NW'(NEEDLE_MAX) : NW'(nlen_cfg_r);
    rlen = (rlen_cfg_r > LEN_W'(REPLACE_MAX)) ? CW'(REPLACE_MAX) : CW'(rlen_cfg_r);
    pc     = (cnt_r >= nlen) ? '0 : cnt_r;
    pc_new = pc + NW'(1);
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      win_new[i*BYTE_W +: BYTE_W] = (pc == NW'(i)) ? in_text_byte
                                                   : win_r[i*BYTE_W +: BYTE_W];
    end
    full  = (pc_new == nlen);
    match = full;
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      if ((NW'(i) < nlen) &&
          (win_new[i*BYTE_W +: BYTE_W] != needle_r[i*BYTE_W +: BYTE_W])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    job_bytes = '0;
    job_cnt   = '0;
    job_end   = in_text_end;
    cnt_nxt   = cnt_r;
    win_nxt   = win_new;
    if (nlen == '0) begin
      job_bytes[BYTE_W-1:0] = in_text_byte;
      job_cnt = CW'(1);
    end else if (match) begin
      for (int i = 0; i < REPLACE_MAX; i++) begin
        job_bytes[i*BYTE_W +: BYTE_W] = repl_r[i*BYTE_W +: BYTE_W];
      end
      job_cnt = rlen;
      cnt_nxt = '0;
    end else begin
      for (int i = 0; i < NEEDLE_MAX; i++) begin
        job_bytes[i*BYTE_W +: BYTE_W] = win_new[i*BYTE_W +: BYTE_W];
      end
      if (full) begin
        job_cnt = in_text_end ? CW'(nlen) : CW'(1);
        cnt_nxt = nlen - NW'(1);
        for (int i = 0; i < NEEDLE_MAX - 1; i++) begin
          win_nxt[i*BYTE_W +: BYTE_W] = win_new[(i+1)*BYTE_W +: BYTE_W];
        end
      end else begin
        job_cnt = in_text_end ? CW'(pc_new) : '0;
        cnt_nxt = pc_new;
      end
    end
    if (in_text_end && (nlen != '0)) begin
      cnt_nxt = '0;
    end
    job_push = in_take && ((job_cnt != '0) || in_text_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nlen_cfg_r <= '0;
      rlen_cfg_r <= '0;
      needle_r   <= '0;
      repl_r     <= '0;
      cnt_r      <= '0;
    end else begin
      if (in_take) begin
        cnt_r <= cnt_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEEDLE_LEN: begin
            nlen_cfg_r <= cfg_data[LEN_W-1:0];
            cnt_r      <= '0;
          end
          CFG_NEEDLE_BYTES: needle_r   <= cfg_data[NEEDLE_MAX*BYTE_W-1:0];
          CFG_REPL_LEN:     rlen_cfg_r <= cfg_data[LEN_W-1:0];
          CFG_REPL_BYTES:   repl_r     <= cfg_data[REPLACE_MAX*BYTE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && (nlen != '0)) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

[design/sfr_back.sv]
// Back part: plays out one queued job a byte per cycle into the output register
// while the output is not stalled. Depends on sfr_pkg.
`default_nettype none

module sfr_back #(
  parameter int JOB_MAX = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_vld,
  input  logic [JOB_MAX*sfr_pkg::BYTE_W-1:0] q_bytes,
  input  logic [$clog2(JOB_MAX+1)-1:0]       q_cnt,
  input  logic                               q_end,
  output logic                               q_pop,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [sfr_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_byte_present,
  output logic                               out_end
);

  import sfr_pkg::*;

  localparam int CW = $clog2(JOB_MAX + 1);
  localparam int IW = (JOB_MAX > 1) ? $clog2(JOB_MAX) : 1;

  logic                        cur_vld_r, cur_end_r;
  logic [JOB_MAX*BYTE_W-1:0]   cur_bytes_r;
  logic [CW-1:0]               cur_cnt_r;
  logic [IW-1:0]               idx_r;
  logic                        out_vld_r, out_present_r, out_end_r;
  logic [BYTE_W-1:0]           out_byte_r;
  logic                        adv, emit, last_item;

  always_comb begin
    last_item = (cur_cnt_r == '0) || ((CW'(idx_r) + CW'(1)) == cur_cnt_r);
    adv       = !out_vld_r || !out_stall;
    emit      = adv && cur_vld_r;
    q_pop     = q_vld && (!cur_vld_r || (emit && last_item));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (q_pop) begin
        cur_vld_r   <= 1'b1;
        cur_bytes_r <= q_bytes;
        cur_cnt_r   <= q_cnt;
        cur_end_r   <= q_end;
        idx_r       <= '0;
      end else if (emit && last_item) begin
        cur_vld_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + IW'(1);
      end
      if (adv) begin
        out_vld_r <= cur_vld_r;
      end
      if (emit) begin
        out_byte_r    <= (cur_cnt_r == '0) ? '0 : cur_bytes_r[idx_r*BYTE_W +: BYTE_W];
        out_present_r <= (cur_cnt_r != '0);
        out_end_r     <= cur_end_r && last_item;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte         = out_byte_r;
  assign out_byte_present = out_present_r;
  assign out_end          = out_end_r;

endmodule

`default_nettype wire

[design/sfr_checker.sv]
// Port-level checker for the stream find-and-replace block, bound to the top.
// Depends on sfr_pkg and stream_find_replace_top_assert.svh.
`default_nettype none

`include "stream_find_replace_top_assert.svh"

module sfr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sfr_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_byte_present,
  input logic                       out_end
);

  `SFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_byte_present) && $stable(out_end), "Stalled result item changed.")
  `SFR_ASSERT_IMPL(a_bare_end, out_valid && !out_byte_present, out_end && (out_byte == '0), "Item without a byte is not a clean end marker.")
  `SFR_ASSERT_RESET(a_rst_out, !out_valid, "Result valid after reset.")
  `SFR_ASSERT_RESET(a_rst_stall, !in_stall, "Input stalled right after reset.")

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (.*);

`default_nettype wire
